FILE: sv/avlc8_pkg.sv
// Shared types, phase codes and helper functions of the Codec 8 packet parser.
`timescale 1ns / 1ps
`default_nettype none
package avlc8_pkg;

   localparam logic [4:0] PH_IDLE    = 5'd0;
   localparam logic [4:0] PH_HEADER  = 5'd1;
   localparam logic [4:0] PH_TIME    = 5'd2;
   localparam logic [4:0] PH_LON     = 5'd4;
   localparam logic [4:0] PH_LAT     = 5'd5;
   localparam logic [4:0] PH_N1      = 5'd12;
   localparam logic [4:0] PH_ID1     = 5'd13;
   localparam logic [4:0] PH_VAL1    = 5'd14;
   localparam logic [4:0] PH_N2      = 5'd15;
   localparam logic [4:0] PH_ID2     = 5'd16;
   localparam logic [4:0] PH_VAL2    = 5'd17;
   localparam logic [4:0] PH_N4      = 5'd18;
   localparam logic [4:0] PH_ID4     = 5'd19;
   localparam logic [4:0] PH_VAL4    = 5'd20;
   localparam logic [4:0] PH_N8      = 5'd21;
   localparam logic [4:0] PH_ID8     = 5'd22;
   localparam logic [4:0] PH_VAL8    = 5'd23;
   localparam logic [4:0] PH_TRAILER = 5'd24;

   localparam logic [4:0] KIND_CODEC   = 5'd0;
   localparam logic [4:0] KIND_COUNT   = 5'd1;
   localparam logic [4:0] KIND_IO1     = 5'd12;
   localparam logic [4:0] KIND_IO2     = 5'd13;
   localparam logic [4:0] KIND_IO4     = 5'd14;
   localparam logic [4:0] KIND_IO8     = 5'd15;
   localparam logic [4:0] KIND_DONE    = 5'd16;
   localparam logic [4:0] KIND_OVERRUN = 5'd17;

   localparam logic [18:0] DIV1000_RECIP = 19'd268436;
   localparam logic [9:0]  DIV1000      = 10'd1000;
   localparam logic [32:0] TRAILER_BYTES = 33'd12;

   typedef struct packed {
      logic [4:0]  field_kind;
      logic [7:0]  record_number;
      logic [7:0]  io_identifier;
      logic [63:0] field_value;
      logic        last_of_packet;
   } result_type;

   function automatic logic [3:0] field_len(input logic [4:0] ph);
      logic [3:0] len;
      case (ph)
         5'd2: len = 4'd8;
         5'd3, 5'd8, 5'd10, 5'd11, PH_VAL1: len = 4'd1;
         5'd4, 5'd5, PH_VAL4: len = 4'd4;
         5'd6, 5'd7, 5'd9, PH_VAL2: len = 4'd2;
         PH_VAL8: len = 4'd8;
         default: len = 4'd0;
      endcase
      return len;
   endfunction

   function automatic logic [4:0] io_kind(input logic [4:0] ph);
      logic [4:0] kind;
      case (ph)
         PH_VAL1: kind = KIND_IO1;
         PH_VAL2: kind = KIND_IO2;
         PH_VAL4: kind = KIND_IO4;
         default: kind = KIND_IO8;
      endcase
      return kind;
   endfunction

endpackage
`default_nettype wire

FILE: sv/avlc8_if.sv
// Handshake interfaces for the input byte channel and the result channel.
`timescale 1ns / 1ps
`default_nettype none
interface avlc8_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       packet_start;
   modport source(output valid, output byte_value, output packet_start, input ready);
   modport sink(input valid, input byte_value, input packet_start, output ready);
endinterface

interface avlc8_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  field_kind;
   logic [7:0]  record_number;
   logic [7:0]  io_identifier;
   logic [63:0] field_value;
   logic        last_of_packet;
   modport source(output valid, output field_kind, output record_number,
                  output io_identifier, output field_value, output last_of_packet,
                  input ready);
   modport sink(input valid, input field_kind, input record_number,
                input io_identifier, input field_value, input last_of_packet,
                output ready);
endinterface
`default_nettype wire

FILE: sv/avlc8_core.sv
// Byte-wise parser state and the result words that each accepted byte produces.
`timescale 1ns / 1ps
`default_nettype none
module avlc8_core import avlc8_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] byte_value,
   input  wire logic       packet_start,
   output logic            res_a_valid,
   output result_type      res_a,
   output logic            res_b_valid,
   output result_type      res_b
);

   logic [31:0] bytes_seen_ff, bytes_seen_in;
   logic [31:0] length_ff, length_in;
   logic [4:0]  phase_ff, phase_in;
   logic [3:0]  fbc_ff, fbc_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] quo_ff, quo_in;
   logic [9:0]  rem_ff, rem_in;
   logic [7:0]  rec_ff, rec_in;
   logic [7:0]  total_ff, total_in;
   logic [7:0]  group_ff, group_in;
   logic [7:0]  ioid_ff, ioid_in;

   logic [3:0]  len;
   logic [3:0]  fbc_next;
   logic [63:0] acc_next;
   logic [17:0] div_x;
   logic [36:0] div_prod;
   logic [7:0]  div_q;
   logic [17:0] div_r;
   logic [63:0] value;
   logic [7:0]  rec_next;
   logic [7:0]  group_next;

   always_comb begin
      len        = field_len(phase_ff);
      fbc_next   = fbc_ff + 4'd1;
      acc_next   = {acc_ff[55:0], byte_value};
      div_x      = {rem_ff, byte_value};
      div_prod   = 37'(div_x) * 37'(DIV1000_RECIP);
      div_q      = div_prod[35:28];
      div_r      = div_x - 18'(div_q) * 18'(DIV1000);
      rec_next   = rec_ff + 8'd1;
      group_next = group_ff - 8'd1;
      value      = acc_next;

      bytes_seen_in = bytes_seen_ff;
      length_in     = length_ff;
      phase_in      = phase_ff;
      fbc_in        = fbc_ff;
      acc_in        = acc_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      rec_in        = rec_ff;
      total_in      = total_ff;
      group_in      = group_ff;
      ioid_in       = ioid_ff;
      res_a_valid   = 1'b0;
      res_a         = '0;
      res_b_valid   = 1'b0;
      res_b         = '0;

      if (accept && packet_start) begin
         if (phase_ff != PH_IDLE) begin
            res_a_valid          = 1'b1;
            res_a.field_kind     = KIND_OVERRUN;
            res_a.record_number  = rec_ff;
            res_a.field_value    = 64'(bytes_seen_ff);
            res_a.last_of_packet = 1'b1;
         end
         bytes_seen_in = 32'd1;
         length_in     = '0;
         phase_in      = PH_HEADER;
         fbc_in        = '0;
         acc_in        = '0;
         quo_in        = '0;
         rem_in        = '0;
         rec_in        = '0;
         total_in      = '0;
         group_in      = '0;
         ioid_in       = '0;
      end else if (accept && phase_ff != PH_IDLE) begin
         if (phase_ff == PH_HEADER) begin
            if (bytes_seen_ff >= 32'd4 && bytes_seen_ff <= 32'd7) begin
               length_in = {length_ff[23:0], byte_value};
            end else if (bytes_seen_ff == 32'd8) begin
               res_a_valid       = 1'b1;
               res_a.field_kind  = KIND_CODEC;
               res_a.field_value = 64'(byte_value);
            end else if (bytes_seen_ff == 32'd9) begin
               res_a_valid       = 1'b1;
               res_a.field_kind  = KIND_COUNT;
               res_a.field_value = 64'(byte_value);
               total_in          = byte_value;
               rec_in            = '0;
               phase_in          = (byte_value == 8'd0) ? PH_TRAILER : PH_TIME;
            end
         end else if (len != 4'd0) begin
            acc_in = acc_next;
            fbc_in = fbc_next;
            if (phase_ff == PH_TIME) begin
               quo_in = {quo_ff[55:0], div_q};
               rem_in = div_r[9:0];
            end
            if (fbc_next >= len) begin
               acc_in = '0;
               fbc_in = '0;
               quo_in = '0;
               rem_in = '0;
               res_a_valid         = 1'b1;
               res_a.record_number = rec_ff;
               if (phase_ff >= PH_VAL1) begin
                  res_a.field_kind    = io_kind(phase_ff);
                  res_a.io_identifier = ioid_ff;
                  res_a.field_value   = acc_next;
                  group_in            = group_next;
                  if (group_next != 8'd0) begin
                     phase_in = phase_ff - 5'd1;
                  end else if (phase_ff == PH_VAL8) begin
                     rec_in   = rec_next;
                     phase_in = (rec_next == total_ff) ? PH_TRAILER : PH_TIME;
                  end else begin
                     phase_in = phase_ff + 5'd1;
                  end
               end else begin
                  if (phase_ff == PH_TIME) begin
                     value = {quo_ff[55:0], div_q};
                  end else if (phase_ff == PH_LON || phase_ff == PH_LAT) begin
                     value = {{32{acc_next[31]}}, acc_next[31:0]};
                  end
                  res_a.field_kind  = phase_ff;
                  res_a.field_value = value;
                  phase_in          = phase_ff + 5'd1;
               end
            end
         end else if (phase_ff == PH_N1 || phase_ff == PH_N2 || phase_ff == PH_N4
                      || phase_ff == PH_N8) begin
            group_in = byte_value;
            if (byte_value != 8'd0) begin
               phase_in = phase_ff + 5'd1;
            end else if (phase_ff == PH_N8) begin
               rec_in   = rec_next;
               phase_in = (rec_next == total_ff) ? PH_TRAILER : PH_TIME;
            end else begin
               phase_in = phase_ff + 5'd3;
            end
         end else if (phase_ff == PH_ID1 || phase_ff == PH_ID2 || phase_ff == PH_ID4
                      || phase_ff == PH_ID8) begin
            ioid_in  = byte_value;
            phase_in = phase_ff + 5'd1;
         end

         if (bytes_seen_ff != 32'hffff_ffff) begin
            bytes_seen_in = bytes_seen_ff + 32'd1;
         end
         if (bytes_seen_in >= 32'd12
             && {1'b0, bytes_seen_in} == ({1'b0, length_in} + TRAILER_BYTES)) begin
            res_b_valid          = 1'b1;
            res_b.field_kind     = KIND_DONE;
            res_b.record_number  = rec_in;
            res_b.field_value    = 64'(total_in);
            res_b.last_of_packet = 1'b1;
            phase_in             = PH_IDLE;
            fbc_in               = '0;
            acc_in               = '0;
            quo_in               = '0;
            rem_in               = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff <= '0;
         length_ff     <= '0;
         phase_ff      <= PH_IDLE;
         fbc_ff        <= '0;
         acc_ff        <= '0;
         quo_ff        <= '0;
         rem_ff        <= '0;
         rec_ff        <= '0;
         total_ff      <= '0;
         group_ff      <= '0;
         ioid_ff       <= '0;
      end else begin
         bytes_seen_ff <= bytes_seen_in;
         length_ff     <= length_in;
         phase_ff      <= phase_in;
         fbc_ff        <= fbc_in;
         acc_ff        <= acc_in;
         quo_ff        <= quo_in;
         rem_ff        <= rem_in;
         rec_ff        <= rec_in;
         total_ff      <= total_in;
         group_ff      <= group_in;
         ioid_ff       <= ioid_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/avlc8_fifo.sv
// Four-entry result queue that takes up to two words per cycle and gives one.
`timescale 1ns / 1ps
`default_nettype none
module avlc8_fifo import avlc8_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       a_valid,
   input  wire result_type a_word,
   input  wire logic       b_valid,
   input  wire result_type b_word,
   output logic            room,
   output logic            out_valid,
   input  wire logic       out_ready,
   output result_type      out_word
);

   result_type  mem_ff [4];
   logic [1:0]  wr_ff, wr_in;
   logic [1:0]  rd_ff, rd_in;
   logic [2:0]  count_ff, count_in;
   logic [1:0]  b_addr;
   logic        pop;

   always_comb begin
      pop       = out_valid && out_ready;
      b_addr    = a_valid ? (wr_ff + 2'd1) : wr_ff;
      wr_in     = wr_ff + 2'(a_valid) + 2'(b_valid);
      rd_in     = rd_ff + 2'(pop);
      count_in  = count_ff + 3'(a_valid) + 3'(b_valid) - 3'(pop);
      room      = count_ff <= 3'd2;
      out_valid = count_ff != 3'd0;
      out_word  = mem_ff[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (a_valid) begin
         mem_ff[wr_ff] <= a_word;
      end
      if (b_valid) begin
         mem_ff[b_addr] <= b_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/avl_codec8_packet_parser_unit.sv
// Top level of the Codec 8 packet parser: byte input, result queue output.
// Result words are registered in the result queue and reach rsp in the order made.
// Throughput: one byte per cycle; a byte may produce two words, which the
// four-entry result queue absorbs, and req ready drops while it holds three or more.
// Reset clears the parser state and empties the result queue.
`timescale 1ns / 1ps
`default_nettype none
module avl_codec8_packet_parser_unit import avlc8_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   avlc8_req_if.sink    req_port,
   avlc8_rsp_if.source  rsp_port
);

   logic       accept;
   logic       room;
   logic       a_valid;
   logic       b_valid;
   result_type a_word;
   result_type b_word;
   result_type out_word;

   assign req_port.ready = room;
   assign accept         = req_port.valid && room;

   avlc8_core u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .byte_value   (req_port.byte_value),
      .packet_start (req_port.packet_start),
      .res_a_valid  (a_valid),
      .res_a        (a_word),
      .res_b_valid  (b_valid),
      .res_b        (b_word)
   );

   avlc8_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .a_valid   (a_valid),
      .a_word    (a_word),
      .b_valid   (b_valid),
      .b_word    (b_word),
      .room      (room),
      .out_valid (rsp_port.valid),
      .out_ready (rsp_port.ready),
      .out_word  (out_word)
   );

   assign rsp_port.field_kind     = out_word.field_kind;
   assign rsp_port.record_number  = out_word.record_number;
   assign rsp_port.io_identifier  = out_word.io_identifier;
   assign rsp_port.field_value    = out_word.field_value;
   assign rsp_port.last_of_packet = out_word.last_of_packet;

endmodule
`default_nettype wire
